/* hdl/pcf_pkg.sv */
// shared types and constants for the pixel colour fade engine
// no dependencies; used by pcf_front, pcf_back and pixel_color_fade_engine
`default_nettype none

package pcf_pkg;

  // default table depth
  localparam int PIXELS_DEF = 9;

  // field widths
  localparam int IDX_W   = 4;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int STEP_W  = 8;
  localparam int BRT_W   = 8;
  localparam int PHASE_W = 7;

  // one table entry: colour a, colour b, step, brightness, phase
  localparam int ENTRY_W = 2 * COLOR_W + STEP_W + BRT_W + PHASE_W;

  // percent arithmetic
  localparam int PCT_FULL = 100;
  localparam int PCT_HALF = 50;
  localparam int CH_MAX   = 255;

  // x / 100 == (x * 5243) >> 19 for every x below 43690
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int ACC_W       = 15;
  localparam int PROD_W      = 28;

  // entries in the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // one queued command
  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   pixel;
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic [STEP_W-1:0]  step;
    logic [BRT_W-1:0]   brightness;
  } pcf_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    pcf_item_t item;
  } pcf_head_t;

endpackage

`default_nettype wire

/* hdl/pcf_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/pcf_front.sv */
// front end: takes input beats, drops out-of-range pixels, queues the rest
// depends on pcf_pkg
`default_nettype none

module pcf_front #(
  parameter int PIXELS = pcf_pkg::PIXELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [pcf_pkg::IDX_W-1:0]           pixel_index,
  input  wire logic [pcf_pkg::COLOR_W-1:0]         color_a,
  input  wire logic [pcf_pkg::COLOR_W-1:0]         color_b,
  input  wire logic signed [pcf_pkg::STEP_W-1:0]   step_size,
  input  wire logic [pcf_pkg::BRT_W-1:0]           brightness,
  output pcf_pkg::pcf_head_t                       head,
  input  wire logic                                pop
);

  localparam int QD = pcf_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  pcf_pkg::pcf_item_t slots [QD];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          in_range;
  logic          push;

  // classify the beat
  always_comb begin
    in_ready = (count != CW'(QD));
    in_range = (32'(pixel_index) < PIXELS);
    push     = in_valid && in_ready && in_range;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{cmd:        cmd,
                         pixel:      pixel_index,
                         color_a:    color_a,
                         color_b:    color_b,
                         step:       step_size,
                         brightness: brightness};
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

endmodule

`default_nettype wire

/* hdl/pcf_back.sv */
// back end: table ram, per-pixel crossfade and fade sequencer, result register
// depends on pcf_pkg and pcf_ram
`default_nettype none

module pcf_back #(
  parameter int PIXELS = pcf_pkg::PIXELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pcf_pkg::pcf_head_t          head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pcf_pkg::IDX_W-1:0]        out_pixel,
  output logic [pcf_pkg::CH_W-1:0]         red,
  output logic [pcf_pkg::CH_W-1:0]         green,
  output logic [pcf_pkg::CH_W-1:0]         blue
);

  localparam int AW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int EW  = pcf_pkg::ENTRY_W;
  localparam int CW  = pcf_pkg::COLOR_W;
  localparam int HW  = pcf_pkg::CH_W;
  localparam int PHW = pcf_pkg::PHASE_W;
  localparam int SW  = pcf_pkg::STEP_W;
  localparam int BW  = pcf_pkg::BRT_W;
  localparam int AC  = pcf_pkg::ACC_W;
  localparam int PR  = pcf_pkg::PROD_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MIX, ST_DIV1, ST_FADE, ST_DIV2, ST_BRIGHT, ST_DIV3, ST_DONE
  } state_t;

  state_t state;

  // table and per-entry valid bits
  logic [PIXELS-1:0] valid;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] entry;

  // working registers for the stepped pixel
  logic [pcf_pkg::IDX_W-1:0] pix;
  logic [AW-1:0]  addr;
  logic [CW-1:0]  ca;
  logic [CW-1:0]  cb;
  logic [SW-1:0]  step;
  logic [BW-1:0]  brt;
  logic [PHW-1:0] phase;
  logic [PHW-1:0] fade;
  logic [PHW-1:0] upd_phase;
  logic [SW-1:0]  upd_step;
  logic [AC-1:0]  acc  [3];
  logic [PR-1:0]  prod [3];

  logic           out_free;
  logic           load_pop;
  logic           step_pop;
  logic [PHW-1:0] entry_phase;
  logic [PHW-1:0] fade_calc;
  logic [PHW-1:0] half_diff;
  logic [PHW-1:0] brt_pct;
  logic signed [SW:0] np;
  logic           bounce;
  logic [AC-1:0]  mix_sum [3];
  logic [8:0]     quot    [3];
  logic [HW-1:0]  quot_sat[3];

  pcf_ram #(
    .WIDTH (EW),
    .DEPTH (PIXELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pop, table write and read address
  always_comb begin
    out_free  = !out_valid || out_ready;
    pop       = head.valid && (state == ST_IDLE);
    load_pop  = pop && (head.item.cmd == pcf_pkg::CMD_LOAD);
    step_pop  = pop && (head.item.cmd == pcf_pkg::CMD_STEP);
    addr      = AW'(pix);
    ram_raddr = AW'(head.item.pixel);
    if (state == ST_DONE) begin
      ram_we    = out_free;
      ram_waddr = addr;
      ram_wdata = {ca, cb, upd_step, brt, upd_phase};
    end else begin
      ram_we    = load_pop;
      ram_waddr = AW'(head.item.pixel);
      ram_wdata = {head.item.color_a, head.item.color_b, head.item.step,
                   head.item.brightness, PHW'(0)};
    end
  end

  // entry fields; an entry never written reads as zero
  always_comb begin
    entry       = valid[addr] ? ram_rdata : '0;
    entry_phase = (entry[PHW-1:0] > PHW'(pcf_pkg::PCT_FULL)) ?
                  PHW'(pcf_pkg::PCT_FULL) : entry[PHW-1:0];
  end

  // triangle fade, next phase and step, brightness percent
  always_comb begin
    half_diff = phase - PHW'(pcf_pkg::PCT_HALF);
    if (phase < PHW'(pcf_pkg::PCT_HALF)) begin
      fade_calc = PHW'(pcf_pkg::PCT_FULL) - {phase[PHW-2:0], 1'b0};
    end else begin
      fade_calc = {half_diff[PHW-2:0], 1'b0};
    end
    np     = $signed({2'b00, phase}) + $signed({step[SW-1], step});
    bounce = (np <= 0) || (np >= (SW+1)'(pcf_pkg::PCT_FULL));
    brt_pct = (brt > BW'(pcf_pkg::PCT_FULL)) ? PHW'(pcf_pkg::PCT_FULL) : brt[PHW-1:0];
  end

  // per-channel products and quotients
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_sum[k] = AC'(ca[CW-1-HW*k -: HW]) * AC'(phase)
                 + AC'(cb[CW-1-HW*k -: HW]) * AC'(PHW'(pcf_pkg::PCT_FULL) - phase);
      quot[k]     = 9'(prod[k] >> pcf_pkg::RECIP_SHIFT);
      quot_sat[k] = (quot[k] > 9'(pcf_pkg::CH_MAX)) ? HW'(pcf_pkg::CH_MAX) : quot[k][HW-1:0];
    end
  end

  // sequencer, valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: loaded on completion, cleared once taken
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (step_pop) begin
            pix   <= head.item.pixel;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          ca    <= entry[EW-1 -: CW];
          cb    <= entry[EW-1-CW -: CW];
          step  <= entry[PHW+BW +: SW];
          brt   <= entry[PHW +: BW];
          phase <= entry_phase;
          state <= ST_MIX;
        end
        ST_MIX: begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= mix_sum[k];
          end
          fade <= fade_calc;
          upd_step <= bounce ? SW'(~step + SW'(1)) : step;
          if (np < 0) begin
            upd_phase <= '0;
          end else if (np > (SW+1)'(pcf_pkg::PCT_FULL)) begin
            upd_phase <= PHW'(pcf_pkg::PCT_FULL);
          end else begin
            upd_phase <= np[PHW-1:0];
          end
          state <= ST_DIV1;
        end
        ST_DIV1, ST_DIV2, ST_DIV3: begin
          for (int k = 0; k < 3; k++) begin
            prod[k] <= PR'(acc[k]) * PR'(pcf_pkg::RECIP_100);
          end
          unique case (state)
            ST_DIV1: state <= ST_FADE;
            ST_DIV2: state <= ST_BRIGHT;
            default: state <= ST_DONE;
          endcase
        end
        ST_FADE: begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= AC'(quot_sat[k]) * AC'(fade);
          end
          state <= ST_DIV2;
        end
        ST_BRIGHT: begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= AC'(quot[k][HW-1:0]) * AC'(brt_pct);
          end
          state <= ST_DIV3;
        end
        ST_DONE: begin
          if (out_free) begin
            out_pixel <= pix;
            red       <= quot[0][HW-1:0];
            green     <= quot[1][HW-1:0];
            blue      <= quot[2][HW-1:0];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pixel_color_fade_engine.sv */
// pixel colour fade engine: a step beat runs from the queue through the
// back-end sequencer to out_valid; a load leaves the queue when the back
// end is idle, one per cycle; a step holds later beats until the sequencer
// ends (read, mix, fade, brightness, each over 100, write-back and result)
// reset: queue empties, result register clears, every table entry reads zero
// through per-entry valid bits, no clearing pass
// depends on pcf_pkg, pcf_front, pcf_back, pcf_ram
`default_nettype none

module pixel_color_fade_engine #(
  parameter int PIXELS = pcf_pkg::PIXELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [pcf_pkg::IDX_W-1:0]           pixel_index,
  input  wire logic [pcf_pkg::COLOR_W-1:0]         color_a,
  input  wire logic [pcf_pkg::COLOR_W-1:0]         color_b,
  input  wire logic signed [pcf_pkg::STEP_W-1:0]   step_size,
  input  wire logic [pcf_pkg::BRT_W-1:0]           brightness,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [pcf_pkg::IDX_W-1:0]                out_pixel,
  output logic [pcf_pkg::CH_W-1:0]                 red,
  output logic [pcf_pkg::CH_W-1:0]                 green,
  output logic [pcf_pkg::CH_W-1:0]                 blue
);

  pcf_pkg::pcf_head_t head;
  logic               pop;

  // accept and classify
  pcf_front #(
    .PIXELS (PIXELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .pixel_index (pixel_index),
    .color_a     (color_a),
    .color_b     (color_b),
    .step_size   (step_size),
    .brightness  (brightness),
    .head        (head),
    .pop         (pop)
  );

  // table update and colour computation
  pcf_back #(
    .PIXELS (PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // the back end only takes from a queue that holds something
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // the front stalls only while the queue holds beats
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> head.valid)
    else $error("front stalled with empty queue");

  // results only ever name a pixel in the table
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (32'(out_pixel) < PIXELS))
    else $error("result for out-of-range pixel");

endmodule

`default_nettype wire
